/* design/fchs_pkg.sv */
// Shared widths, register indexes and the divider status type for the fan curve controller.
`timescale 1ns / 1ps

package fchs_pkg;

   // Field and register widths.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int TEMP_W     = 8;
   localparam int DUTY_W     = 8;
   localparam int LEVEL_W    = 3;
   localparam int RPM_W      = 16;
   localparam int TACH_W     = 16;
   localparam int NUMER_W    = 32;
   localparam int HYS_W      = 5;
   localparam int PCOUNT_W   = 4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_TEMPS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_DUTIES   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_FLOOR     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_FULL      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS_DEG = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RPM_NUMERATOR  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GPU_TEMP_USED  = 3'd7;

   // Status of the serial divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* design/fchs_req_if.sv */
// Request channel carrying one tick item to the fan controller.
`timescale 1ns / 1ps

interface fchs_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     cmd;
   logic signed [fchs_pkg::TEMP_W-1:0]       cpu_temp;
   logic signed [fchs_pkg::TEMP_W-1:0]       gpu_temp;
   logic                                     full_speed;
   logic                                     in_s0;
   logic        [fchs_pkg::TACH_W-1:0]       tach_count;

   modport source (output valid, cmd, cpu_temp, gpu_temp, full_speed, in_s0, tach_count,
                   input ready);
   modport sink (input valid, cmd, cpu_temp, gpu_temp, full_speed, in_s0, tach_count,
                 output ready);
endinterface

/* design/fchs_rsp_if.sv */
// Response channel carrying the controller state after each tick.
`timescale 1ns / 1ps

interface fchs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [fchs_pkg::DUTY_W-1:0]       duty_target;
   logic [fchs_pkg::DUTY_W-1:0]       duty_actual;
   logic [fchs_pkg::RPM_W-1:0]        fan_rpm;
   logic [fchs_pkg::LEVEL_W-1:0]      curve_level;

   modport source (output valid, duty_target, duty_actual, fan_rpm, curve_level,
                   input ready);
   modport sink (input valid, duty_target, duty_actual, fan_rpm, curve_level,
                 output ready);
endinterface

/* design/fchs_div.sv */
// Bit-serial restoring divider that turns a tach count into a saturated RPM value.
`timescale 1ns / 1ps

module fchs_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [fchs_pkg::NUMER_W-1:0]      numerator,
   input  logic [fchs_pkg::TACH_W-1:0]       divisor,
   output fchs_pkg::div_stat_type            stat,
   output logic [fchs_pkg::RPM_W-1:0]        rpm
);

   localparam int CntW = $clog2(fchs_pkg::NUMER_W);

   logic [fchs_pkg::NUMER_W-1:0] num_ff, num_in;
   logic [fchs_pkg::TACH_W-1:0]  den_ff, den_in;
   logic [fchs_pkg::TACH_W-1:0]  rem_ff, rem_in;
   logic [fchs_pkg::RPM_W-1:0]   quo_ff, quo_in;
   logic                         sat_ff, sat_in;
   logic [CntW-1:0]              cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;

   logic [fchs_pkg::TACH_W:0]    trial;
   logic [fchs_pkg::TACH_W:0]    diff;
   logic                         fits;

   // One quotient bit per cycle: bring down the next numerator bit and try a subtract.
   assign trial = {rem_ff, num_ff[fchs_pkg::NUMER_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numerator;
         den_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
         sat_in  = 1'b0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[fchs_pkg::NUMER_W-2:0], 1'b0};
         rem_in = fits ? diff[fchs_pkg::TACH_W-1:0] : trial[fchs_pkg::TACH_W-1:0];
         // A one shifted out of the 16-bit quotient window means the result saturates.
         sat_in = sat_ff | quo_ff[fchs_pkg::RPM_W-1];
         quo_in = {quo_ff[fchs_pkg::RPM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(fchs_pkg::NUMER_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state. The divisor is cleared so the result reads zero before the first division.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         den_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         den_ff  <= den_in;
      end
   end

   // Datapath shift registers.
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   // A stopped fan reads zero; an oversized quotient clamps to all ones.
   assign rpm = (den_ff == '0) ? '0 : (sat_ff ? '1 : quo_ff);

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   // A finished division leaves the unit idle.
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider reports done while still busy");

   // Done follows the last step of a running division.
   assert property (@(posedge clock) disable iff (reset)
                    done_ff |-> $past(busy_ff) && !$past(start))
      else $error("divider done without a running division");

   // The result stays put while the unit is idle and not restarted.
   assert property (@(posedge clock) disable iff (reset)
                    !busy_ff && !start |=> $stable(rpm))
      else $error("divider result changed while idle");

endmodule

/* design/fan_curve_hysteresis_slew.sv */
// Top level of the single-fan curve controller with hysteresis, duty slew and tach RPM.
//
//   channel   direction  transfer when        carries
//   req_ch    in         valid && ready      cmd, temps, full_speed, in_s0, tach_count
//   rsp_ch    out        valid && ready      target, actual duty, rpm, curve level
//   csr_*     in         csr_we high         index and data of one control register
//
// A target tick compares one point of the curve per cycle, scanning all MAX_POINTS points.
// A duty tick waits on the bit-serial 32-by-16 divider that computes RPM.
// One item is in work at a time; the next is accepted while a result waits on rsp_ch.
// Synchronous reset clears the state registers and loads the register reset values.
// A stalled rsp_ch holds the finished item's state back until its result is taken.
`timescale 1ns / 1ps

module fan_curve_hysteresis_slew #(
   parameter int MAX_POINTS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   fchs_req_if.sink                            req_ch,
   fchs_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [fchs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fchs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CntW = $clog2(MAX_POINTS + 1);
   localparam logic [fchs_pkg::PCOUNT_W-1:0] MaxPts = fchs_pkg::PCOUNT_W'(MAX_POINTS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   // Control registers.
   logic [63:0]                         curve_temps_ff;
   logic [63:0]                         curve_duties_ff;
   logic [fchs_pkg::PCOUNT_W-1:0]       point_count_ff;
   logic [fchs_pkg::DUTY_W-1:0]         duty_floor_ff;
   logic [fchs_pkg::DUTY_W-1:0]         duty_full_ff;
   logic [fchs_pkg::HYS_W-1:0]          hysteresis_ff;
   logic [fchs_pkg::NUMER_W-1:0]        rpm_numerator_ff;
   logic                                gpu_used_ff;

   // Sequencer and item registers.
   logic [1:0]                          state_ff, state_in;
   logic                                cmd_ff, cmd_in;
   logic                                full_ff, full_in;
   logic                                s0_ff, s0_in;
   logic signed [fchs_pkg::TEMP_W-1:0]  temp_ff, temp_in;
   logic [63:0]                         ts_ff, ts_in;
   logic [CntW-1:0]                     k_ff, k_in;
   logic [CntW-1:0]                     up_ff, up_in;
   logic [CntW-1:0]                     down_ff, down_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   // Controller state, which doubles as the response register.
   logic [fchs_pkg::LEVEL_W-1:0]        level_ff, level_in;
   logic [fchs_pkg::DUTY_W-1:0]         target_ff, target_in;
   logic [fchs_pkg::DUTY_W-1:0]         actual_ff, actual_in;
   logic [fchs_pkg::RPM_W-1:0]          rpm_ff, rpm_in;

   logic                                accept;
   logic                                commit;
   logic [CntW-1:0]                     n_use;
   logic signed [fchs_pkg::TEMP_W-1:0]  pick_temp;
   logic signed [fchs_pkg::TEMP_W-1:0]  pt;
   logic signed [fchs_pkg::TEMP_W:0]    pt_hys;
   logic signed [fchs_pkg::TEMP_W:0]    temp_wide;
   logic                                below_up;
   logic                                below_down;
   logic [3:0]                          lvl_a, lvl_b, lvl_c, n_m1;
   logic [fchs_pkg::DUTY_W-1:0]         slew_up, slew_dn, slew_duty;

   fchs_pkg::div_stat_type              div_stat;
   logic [fchs_pkg::RPM_W-1:0]          div_rpm;

   assign accept = req_ch.valid && req_ch.ready;
   assign commit = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = (state_ff == ST_IDLE);

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         curve_temps_ff   <= '0;
         curve_duties_ff  <= '0;
         point_count_ff   <= fchs_pkg::PCOUNT_W'(1);
         duty_floor_ff    <= '0;
         duty_full_ff     <= '1;
         hysteresis_ff    <= fchs_pkg::HYS_W'(5);
         rpm_numerator_ff <= '0;
         gpu_used_ff      <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            fchs_pkg::CSR_CURVE_TEMPS:    curve_temps_ff   <= csr_wdata;
            fchs_pkg::CSR_CURVE_DUTIES:   curve_duties_ff  <= csr_wdata;
            fchs_pkg::CSR_POINT_COUNT:    point_count_ff   <= csr_wdata[fchs_pkg::PCOUNT_W-1:0];
            fchs_pkg::CSR_DUTY_FLOOR:     duty_floor_ff    <= csr_wdata[fchs_pkg::DUTY_W-1:0];
            fchs_pkg::CSR_DUTY_FULL:      duty_full_ff     <= csr_wdata[fchs_pkg::DUTY_W-1:0];
            fchs_pkg::CSR_HYSTERESIS_DEG: hysteresis_ff    <= csr_wdata[fchs_pkg::HYS_W-1:0];
            fchs_pkg::CSR_RPM_NUMERATOR:  rpm_numerator_ff <= csr_wdata[fchs_pkg::NUMER_W-1:0];
            fchs_pkg::CSR_GPU_TEMP_USED:  gpu_used_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Points in use, with zero read as one and overlarge counts clamped.
   always_comb begin
      if (point_count_ff == '0) begin
         n_use = CntW'(1);
      end else if (point_count_ff > MaxPts) begin
         n_use = CntW'(MAX_POINTS);
      end else begin
         n_use = CntW'(point_count_ff);
      end
   end

   // Controlling temperature, the higher of CPU and GPU when the GPU is used.
   assign pick_temp = (gpu_used_ff && (req_ch.gpu_temp > req_ch.cpu_temp)) ?
                      req_ch.gpu_temp : req_ch.cpu_temp;

   // Point under test sits in the low byte of the temperature shift register.
   assign pt         = $signed(ts_ff[7:0]);
   assign pt_hys     = {pt[fchs_pkg::TEMP_W-1], pt} - $signed({4'b0000, hysteresis_ff});
   assign temp_wide  = {temp_ff[fchs_pkg::TEMP_W-1], temp_ff};
   assign below_up   = (temp_ff < pt);
   assign below_down = (temp_wide < pt_hys);

   // Level moves up to the heating point, down to the cooling point, then clamps.
   always_comb begin
      lvl_a = ({1'b0, level_ff} < 4'(up_ff)) ? 4'(up_ff) : {1'b0, level_ff};
      lvl_b = (lvl_a > 4'(down_ff)) ? 4'(down_ff) : lvl_a;
      n_m1  = 4'(n_use) - 4'd1;
      lvl_c = (lvl_b > n_m1) ? n_m1 : lvl_b;
   end

   // One slew step toward the target, honoring the floor and full duty.
   always_comb begin
      slew_up = actual_ff + 1'b1;
      if (slew_up < duty_floor_ff) begin
         slew_up = duty_floor_ff;
      end
      slew_dn = actual_ff - 1'b1;
      if (slew_dn < duty_floor_ff) begin
         slew_dn = '0;
      end
      if (actual_ff < target_ff) begin
         slew_duty = (actual_ff < duty_full_ff) ? slew_up : actual_ff;
      end else if (actual_ff > target_ff) begin
         slew_duty = slew_dn;
      end else begin
         slew_duty = actual_ff;
      end
   end

   // Sequencer: accept, scan or divide, then commit when the response slot is free.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      full_in      = full_ff;
      s0_in        = s0_ff;
      temp_in      = temp_ff;
      ts_in        = ts_ff;
      k_in         = k_ff;
      up_in        = up_ff;
      down_in      = down_ff;
      level_in     = level_ff;
      target_in    = target_ff;
      actual_in    = actual_ff;
      rpm_in       = rpm_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_ch.cmd;
               full_in  = req_ch.full_speed;
               s0_in    = req_ch.in_s0;
               temp_in  = pick_temp;
               ts_in    = curve_temps_ff;
               k_in     = '0;
               up_in    = n_use;
               down_in  = n_use;
               state_in = req_ch.cmd ? ST_DIV : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // First point above the temperature wins; k below the mark also means k < n.
            if ((k_ff < up_ff) && below_up) begin
               up_in = k_ff;
            end
            if ((k_ff < down_ff) && below_down) begin
               down_in = k_ff;
            end
            ts_in = {8'h00, ts_ff[63:8]};
            k_in  = k_ff + 1'b1;
            if (k_ff == CntW'(MAX_POINTS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (!cmd_ff) begin
                  if (full_ff) begin
                     target_in = duty_full_ff;
                  end else if (!s0_ff) begin
                     target_in = '0;
                  end else begin
                     level_in  = lvl_c[fchs_pkg::LEVEL_W-1:0];
                     // Below point 0 less hysteresis the fan is off.
                     target_in = (down_ff == '0) ? '0 :
                                 curve_duties_ff[lvl_c[fchs_pkg::LEVEL_W-1:0]*8 +: 8];
                  end
               end else begin
                  if (full_ff) begin
                     actual_in = duty_full_ff;
                  end else if (!s0_ff) begin
                     actual_in = '0;
                  end else begin
                     actual_in = slew_duty;
                  end
                  rpm_in = div_rpm;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         target_ff    <= '0;
         actual_ff    <= '0;
         rpm_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         target_ff    <= target_in;
         actual_ff    <= actual_in;
         rpm_ff       <= rpm_in;
      end
   end

   // Item and scan registers.
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      full_ff <= full_in;
      s0_ff   <= s0_in;
      temp_ff <= temp_in;
      ts_ff   <= ts_in;
      k_ff    <= k_in;
      up_ff   <= up_in;
      down_ff <= down_in;
   end

   fchs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (accept && req_ch.cmd),
      .numerator (rpm_numerator_ff),
      .divisor   (req_ch.tach_count),
      .stat      (div_stat),
      .rpm       (div_rpm)
   );

   // Response payload is the controller state itself.
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.duty_target = target_ff;
   assign rsp_ch.duty_actual = actual_ff;
   assign rsp_ch.fan_rpm     = rpm_ff;
   assign rsp_ch.curve_level = level_ff;

   // A response waiting on a stall keeps the state it reports.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff && !rsp_ch.ready |=>
                    $stable(target_ff) && $stable(actual_ff) && $stable(rpm_ff) &&
                    $stable(level_ff))
      else $error("state changed under a stalled response");

   // The divider finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
                    div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide wait");

   // A new division never starts on top of a running one.
   assert property (@(posedge clock) disable iff (reset)
                    accept && req_ch.cmd |-> !div_stat.busy)
      else $error("division started while divider busy");

   // A target tick leaves the actual duty and the RPM alone.
   assert property (@(posedge clock) disable iff (reset)
                    commit && !cmd_ff |=> $stable(actual_ff) && $stable(rpm_ff))
      else $error("target tick changed duty or rpm");

   // The curve level moves only when a target tick commits.
   assert property (@(posedge clock) disable iff (reset)
                    !(commit && !cmd_ff) |=> $stable(level_ff))
      else $error("curve level changed outside a target tick");

endmodule
